[src/lrsg_pkg.sv]
// Package: types, constants and helpers for the late-reverb spectral gain block.
package lrsg_pkg;

  localparam int BINS = 512;
  localparam int TAPS = 8;
  localparam int BIN_W = $clog2(BINS);
  localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int HIST_DEPTH = BINS * TAPS;
  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int MAG_W = 17;
  localparam int SNR_W = 32;

  localparam logic [1:0] CFG_ETA   = 2'd0;
  localparam logic [1:0] CFG_ALPHA = 2'd1;
  localparam logic [1:0] CFG_BETA  = 2'd2;
  localparam logic [1:0] CFG_FLOOR = 2'd3;

  localparam logic [1:0] BETA_HALF = 2'd0;
  localparam logic [1:0] BETA_TWO  = 2'd2;

  localparam logic REQ_BIN  = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [8:0]  bin_index;
    logic signed [15:0] bin_re;
    logic signed [15:0] bin_im;
    logic [2:0]  tap_index;
    logic [15:0] tap_weight;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic [15:0] out_gain;
    logic [8:0]  out_bin;
  } out_item_t;

  typedef struct packed {
    logic [15:0] eta;
    logic [31:0] alpha;
    logic [1:0]  beta;
    logic [15:0] gfloor;
  } cfg_t;

  // Classified work passed from front to back.
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [32:0] power;
    logic [TAP_W-1:0] slot;
  } job_t;

endpackage

[src/lrsg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module lrsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/lrsg_front.sv]
// Front: accepts items, loads tap weights, computes power and frame slot, queues jobs.
module lrsg_front
  import lrsg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_take,
  output job_t     job,
  output logic [TAPS-1:0][15:0] weights,
  input  logic     back_idle
);
  localparam int QD = 2;

  job_t q_r [QD];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;
  logic [TAP_W-1:0] slot_r;
  logic [TAPS-1:0][15:0] wt_r;
  logic acc, push, pop;
  logic signed [31:0] pre, pim;
  job_t nj;

  // hold a weight load until every queued bin has finished
  assign in_stall = (cnt_r == 2'(QD)) ||
                    (in_valid && in_data.req_type == REQ_LOAD &&
                     (cnt_r != 2'd0 || !back_idle));
  assign acc = in_valid && !in_stall;
  assign push = acc && in_data.req_type == REQ_BIN && 32'(in_data.bin_index) < BINS;
  assign pop = job_valid && job_take;
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rd_r];
  assign weights = wt_r;

  always_comb begin
    pre = in_data.bin_re * in_data.bin_re;
    pim = in_data.bin_im * in_data.bin_im;
    nj.bin = BIN_W'(in_data.bin_index);
    nj.re = in_data.bin_re;
    nj.im = in_data.bin_im;
    nj.power = {1'b0, pre} + {1'b0, pim};
    nj.slot = slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      slot_r <= '0;
      wt_r <= '0;
    end else begin
      if (acc && in_data.req_type == REQ_LOAD && 32'(in_data.tap_index) < TAPS) begin
        wt_r[TAP_W'(in_data.tap_index)] <= in_data.tap_weight;
      end
      if (push) begin
        q_r[wr_r] <= nj;
        wr_r <= ~wr_r;
        if (32'(in_data.bin_index) == BINS - 1) begin
          slot_r <= (32'(slot_r) == TAPS - 1) ? '0 : slot_r + 1'b1;
        end
      end
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QD))
    else $error("queue overflow");
  a_nopop: assert property (@(posedge clk) disable iff (!rst_n) cnt_r == 0 |-> !pop)
    else $error("pop from empty queue");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'(QD) && !pop |=> cnt_r == 2'(QD))
    else $error("full queue drained without pop");
`endif
endmodule

[src/lrsg_back.sv]
// Back: per-bin sequencer for magnitude, estimate, SNR smoothing, gain and scaling.
module lrsg_back
  import lrsg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic job_valid,
  output logic job_take,
  input  job_t job,
  input  logic [TAPS-1:0][15:0] weights,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data,
  output logic idle
);
  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_SQRT, S_HRD, S_HACC, S_DIV1, S_XI, S_DIV2, S_GAIN, S_GSQ,
    S_SCALE, S_OUT
  } st_t;

  st_t st_r;
  job_t j_r;
  logic [HIST_AW-1:0] clr_r;
  logic [TAP_W:0] t_r;
  logic [6:0] it_r;
  logic [65:0] rem_r;
  logic [65:0] quo_r;
  logic [65:0] den_r;
  logic [33:0] sq_res_r, sq_v_r;
  logic [MAG_W-1:0] mag_r;
  logic [39:0] lam_r;
  logic [15:0] g_r;
  logic [1:0] sel_r;
  logic [63:0] acc_r;
  logic [15:0] ore_r, oim_r;
  logic ovalid_r;

  logic h_we, s_we;
  logic [HIST_AW-1:0] h_wa, h_ra;
  logic [MAG_W-1:0] h_wd, h_rd;
  logic [BIN_W-1:0] s_wa;
  logic [SNR_W-1:0] s_wd, s_rd;
  logic [TAP_W-1:0] rslot;
  logic [65:0] trial;
  logic [33:0] sq_try, sq_sq, sq_res_nxt;
  logic [48:0] mre, mim;

  lrsg_ram #(.WIDTH(MAG_W), .DEPTH(HIST_DEPTH)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  lrsg_ram #(.WIDTH(SNR_W), .DEPTH(BINS)) u_snr (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(j_r.bin), .rdata(s_rd));

  assign job_take = (st_r == S_IDLE) && !ovalid_r;
  assign idle = (st_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data = '{out_re: ore_r, out_im: oim_r, out_gain: g_r,
                      out_bin: 9'(j_r.bin)};

  always_comb begin
    rslot = TAP_W'((32'(j_r.slot) + TAPS - 32'(t_r)) % TAPS);
    h_ra = HIST_AW'(32'(rslot) * BINS + 32'(j_r.bin));
    h_we = (st_r == S_CLR) || (st_r == S_HRD && t_r == '0);
    h_wa = (st_r == S_CLR) ? clr_r : HIST_AW'(32'(j_r.slot) * BINS + 32'(j_r.bin));
    h_wd = (st_r == S_CLR) ? '0 : MAG_W'(sq_res_r);
    trial = {rem_r[64:0], quo_r[65]};
    sq_try = sq_res_r | (34'(1) << it_r[4:0]);
    sq_sq = 34'(sq_try[16:0]) * 34'(sq_try[16:0]);
    sq_res_nxt = (sq_sq <= sq_v_r) ? sq_try : sq_res_r;
    mre = 49'(signed'({{17{j_r.re[15]}}, j_r.re}) * signed'({1'b0, g_r}) + 49'sh80000000);
    mim = 49'(signed'({{17{j_r.im[15]}}, j_r.im}) * signed'({1'b0, g_r}) + 49'sh80000000);
    s_we = (st_r == S_CLR && 32'(clr_r) < BINS) || (st_r == S_XI);
    s_wa = (st_r == S_CLR) ? BIN_W'(clr_r) : j_r.bin;
    s_wd = (st_r == S_CLR) ? '0 : acc_r[47:16] ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      ovalid_r <= 1'b0;
      t_r <= '0;
      it_r <= '0;
    end else begin
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == HIST_DEPTH - 1) st_r <= S_IDLE;
        end
        S_IDLE: if (job_valid && job_take) begin
          j_r <= job;
          sq_v_r <= {1'b0, job.power};
          sq_res_r <= '0;
          it_r <= 7'd16;
          st_r <= S_SQRT;
        end
        S_SQRT: begin
          // one result bit of floor(sqrt(power)) per cycle
          sq_res_r <= sq_res_nxt;
          if (it_r == 0) begin
            st_r <= S_HRD;
            t_r <= '0;
            lam_r <= '0;
          end else it_r <= it_r - 1'b1;
        end
        S_HRD: begin
          if (t_r == '0) mag_r <= MAG_W'(sq_res_r);
          st_r <= S_HACC;
        end
        S_HACC: begin
          lam_r <= lam_r + 40'(t_r == '0 ? mag_r : h_rd) *
                           40'(weights[TAP_W'(t_r)]);
          if (32'(t_r) == TAPS - 1) begin
            st_r <= S_DIV1;
            quo_r <= {16'b0, j_r.power, 17'b0};
            rem_r <= '0;
            it_r <= 7'd66;
          end else begin
            t_r <= t_r + 1'b1;
            st_r <= S_HRD;
          end
        end
        S_DIV1: begin
          if (lam_r == 0) begin
            acc_r <= '0;
            st_r <= S_XI;
          end else begin
            if (trial >= {26'b0, lam_r}) begin
              rem_r <= trial - {26'b0, lam_r};
              quo_r <= {quo_r[64:0], 1'b1};
            end else begin
              rem_r <= trial;
              quo_r <= {quo_r[64:0], 1'b0};
            end
            it_r <= it_r - 1'b1;
            if (it_r == 7'd1) begin
              st_r <= S_XI;
              sel_r <= 2'd0;
            end
          end
        end
        S_XI: begin
          if (lam_r == 0) begin
            g_r <= '0;
            ore_r <= '0;
            oim_r <= '0;
            st_r <= S_OUT;
          end else if (sel_r == 2'd0) begin
            den_r[31:0] <= (quo_r > 66'hFFFFFFFF) ? 32'hFFFFFFFF : quo_r[31:0];
            sel_r <= 2'd1;
          end else if (sel_r == 2'd1) begin
            acc_r <= 64'(cfg.eta) * 64'(s_rd) +
                     64'(17'h10000 - 17'(cfg.eta)) *
                     64'((den_r[31:0] > 32'h10000) ? den_r[31:0] - 32'h10000 : 32'h0);
            sel_r <= 2'd2;
          end else begin
            quo_r <= {2'b0, acc_r[47:16], 32'b0} >> 16;
            den_r <= 66'(acc_r[47:16]) + 66'(cfg.alpha);
            rem_r <= '0;
            it_r <= 7'd66;
            st_r <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (den_r[32:0] == 0) begin
            quo_r <= '0;
            st_r <= S_GAIN;
          end else begin
            if (trial >= den_r) begin
              rem_r <= trial - den_r;
              quo_r <= {quo_r[64:0], 1'b1};
            end else begin
              rem_r <= trial;
              quo_r <= {quo_r[64:0], 1'b0};
            end
            it_r <= it_r - 1'b1;
            if (it_r == 7'd1) st_r <= S_GAIN;
          end
        end
        S_GAIN: begin
          den_r[15:0] <= (quo_r > 66'hFFFF) ? 16'hFFFF : quo_r[15:0];
          sq_v_r <= {2'b0, ((quo_r > 66'hFFFF) ? 16'hFFFF : quo_r[15:0]), 16'b0};
          sq_res_r <= '0;
          it_r <= 7'd16;
          st_r <= S_GSQ;
        end
        S_GSQ: begin
          priority if (cfg.beta == BETA_HALF) begin
            sq_res_r <= sq_res_nxt;
            if (it_r == 0) begin
              g_r <= (sq_res_nxt > 34'hFFFF) ? 16'hFFFF : sq_res_nxt[15:0];
              st_r <= S_SCALE;
            end else it_r <= it_r - 1'b1;
          end else if (cfg.beta == BETA_TWO) begin
            g_r <= 16'((32'(den_r[15:0]) * 32'(den_r[15:0])) >> 16);
            st_r <= S_SCALE;
          end else begin
            g_r <= den_r[15:0];
            st_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (g_r < cfg.gfloor) begin
            g_r <= cfg.gfloor;
          end else begin
            ore_r <= 16'(49'(mre >> 16) - 49'd32768);
            oim_r <= 16'(49'(mim >> 16) - 49'd32768);
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_r || !out_stall) begin
            ovalid_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  a_take: assert property (@(posedge clk) disable iff (!rst_n) job_take |-> st_r == S_IDLE)
    else $error("job taken while busy");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n) st_r == S_CLR |-> !out_valid)
    else $error("result during clearing pass");
`endif
endmodule

[src/late_reverb_spectral_gain.sv]
// Top level of the late-reverb spectral gain block.
//  channel | ports                         | direction
//  input   | in_valid in_stall in_data     | items in
//  output  | out_valid out_stall out_data  | results out
//  config  | cfg_we cfg_index cfg_data     | register writes
// A bin passes through two bit-serial dividers and bit-serial root steps; the back takes no new bin until then.
// After reset a clearing pass over all BINS*TAPS history entries runs before bins are processed.
// A two-entry queue between front and back absorbs an output stall.
// A weight load stalls until all queued bins have finished.
module late_reverb_spectral_gain
  import lrsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  cfg_t cfg_r;
  logic jv, jt, bidle;
  job_t jb;
  logic [TAPS-1:0][15:0] w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{eta: 16'd32768, alpha: 32'd65536, beta: 2'd1, gfloor: 16'd6554};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ETA:   cfg_r.eta <= cfg_data[15:0];
        CFG_ALPHA: cfg_r.alpha <= cfg_data;
        CFG_BETA:  cfg_r.beta <= cfg_data[1:0];
        CFG_FLOOR: cfg_r.gfloor <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lrsg_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .job_valid(jv), .job_take(jt), .job(jb), .weights(w), .back_idle(bidle));

  lrsg_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .job_valid(jv), .job_take(jt), .job(jb),
    .weights(w), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .idle(bidle));
endmodule
